/* sv/pearson_correlation_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the correlation block
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PEARSON_CORRELATION_ASSERT_SVH
`define PEARSON_CORRELATION_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cond holds at every clock edge.
`define PCC_CHECK(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pcc check failed");
// Check that cons holds in every cycle in which ante holds.
`define PCC_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcc implication failed");
`else
`define PCC_CHECK(lbl, cond)
`define PCC_IMPLY(lbl, ante, cons)
`endif
`endif

/* sv/pcc_pkg.sv */
// ----------------------------------------------------------------------------
// Correlation package
// Shared constants and the snapshot of the running sums for one vector pair.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_LEN     = 65536;
	localparam int CNT_W       = 17;

	typedef struct packed {
		logic [CNT_W-1:0]   n;
		logic signed [32:0] sa;
		logic signed [32:0] sb;
		logic [46:0]        saa;
		logic [46:0]        sbb;
		logic signed [47:0] sab;
		logic               ovf;
	} snap_t;

endpackage

/* sv/pcc_in_if.sv */
// ----------------------------------------------------------------------------
// Pair channel
// Valid/ready channel carrying one element pair and its last mark.
// ----------------------------------------------------------------------------
interface pcc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_a;
	logic signed [15:0] sample_b;
	logic               last;

	modport source (output valid, output sample_a, output sample_b, output last, input ready);
	modport sink (input valid, input sample_a, input sample_b, input last, output ready);
endinterface

/* sv/pcc_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one correlation result with its flags.
// ----------------------------------------------------------------------------
interface pcc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] correlation;
	logic               degenerate;
	logic               overflow;

	modport source (output valid, output correlation, output degenerate, output overflow,
		input ready);
	modport sink (input valid, input correlation, input degenerate, input overflow,
		output ready);
endinterface

/* sv/pcc_front.sv */
// ----------------------------------------------------------------------------
// Correlation front end
// Accept pairs, keep the running sums, push a snapshot on the last pair.
// ----------------------------------------------------------------------------
module pcc_front (
	input  logic            clk,
	input  logic            arst_n,
	pcc_in_if.sink          pairs,
	input  logic            full,
	output logic            push,
	output pcc_pkg::snap_t  snap
);

	logic [pcc_pkg::CNT_W-1:0] cnt_q;
	logic signed [32:0]        sa_q, sb_q;
	logic [46:0]               saa_q, sbb_q;
	logic signed [47:0]        sab_q;
	logic                      ovf_q;

	logic signed [15:0] a_s, b_s;
	logic signed [31:0] prod_aa, prod_bb, prod_ab;
	logic               acc, fire;
	pcc_pkg::snap_t     nx;

	assign a_s = 16'($signed(pairs.sample_a[pcc_pkg::SAMPLE_BITS-1:0]));
	assign b_s = 16'($signed(pairs.sample_b[pcc_pkg::SAMPLE_BITS-1:0]));
	assign prod_aa = a_s * a_s;
	assign prod_bb = b_s * b_s;
	assign prod_ab = a_s * b_s;

	assign acc  = cnt_q < pcc_pkg::CNT_W'(pcc_pkg::MAX_LEN);
	assign fire = pairs.valid && pairs.ready;

	always_comb begin
		nx.n   = cnt_q;
		nx.sa  = sa_q;
		nx.sb  = sb_q;
		nx.saa = saa_q;
		nx.sbb = sbb_q;
		nx.sab = sab_q;
		nx.ovf = ovf_q | !acc;
		if (acc) begin
			nx.n   = cnt_q + 1'b1;
			nx.sa  = sa_q + 33'(a_s);
			nx.sb  = sb_q + 33'(b_s);
			nx.saa = saa_q + 47'($unsigned(prod_aa));
			nx.sbb = sbb_q + 47'($unsigned(prod_bb));
			nx.sab = sab_q + 48'(prod_ab);
		end
	end

	// hold off while the queue has no room for a snapshot
	assign pairs.ready = !full;
	assign push        = fire && pairs.last;
	assign snap        = nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
			saa_q <= '0;
			sbb_q <= '0;
			sab_q <= '0;
			ovf_q <= 1'b0;
		end else if (fire) begin
			if (pairs.last) begin
				cnt_q <= '0;
				sa_q  <= '0;
				sb_q  <= '0;
				saa_q <= '0;
				sbb_q <= '0;
				sab_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= nx.n;
				sa_q  <= nx.sa;
				sb_q  <= nx.sb;
				saa_q <= nx.saa;
				sbb_q <= nx.sbb;
				sab_q <= nx.sab;
				ovf_q <= nx.ovf;
			end
		end
	end

endmodule

/* sv/pcc_fifo.sv */
// ----------------------------------------------------------------------------
// Snapshot queue
// Two-entry queue between the front end and the finishing unit.
// ----------------------------------------------------------------------------
module pcc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcc_pkg::snap_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output pcc_pkg::snap_t rdata
);

	pcc_pkg::snap_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* sv/pcc_back.sv */
// ----------------------------------------------------------------------------
// Correlation finishing unit
// Form the variances and covariance with a serial multiplier, then find the
// rounded quotient bit by bit and hold the result for the receiver.
// ----------------------------------------------------------------------------
`include "pearson_correlation_assert.svh"

module pcc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  pcc_pkg::snap_t snap,
	output logic           pop,
	pcc_out_if.source      result
);

	localparam int SW = 194;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOAD   = 7'b0000010,
		ST_MUL    = 7'b0000100,
		ST_POST   = 7'b0001000,
		ST_SRCH_A = 7'b0010000,
		ST_SRCH_B = 7'b0100000,
		ST_DONE   = 7'b1000000
	} st_t;

	localparam logic [2:0] OP_N_SAA = 3'd0;
	localparam logic [2:0] OP_SA_SQ = 3'd1;
	localparam logic [2:0] OP_N_SBB = 3'd2;
	localparam logic [2:0] OP_SB_SQ = 3'd3;
	localparam logic [2:0] OP_N_SAB = 3'd4;
	localparam logic [2:0] OP_SA_SB = 3'd5;
	localparam logic [2:0] OP_VAR   = 3'd6;
	localparam logic [2:0] OP_MAG   = 3'd7;

	function automatic logic [63:0] abs64(input logic [63:0] x);
		return x[63] ? 64'd0 - x : x;
	endfunction

	st_t              st_q;
	pcc_pkg::snap_t   snap_q;
	logic [2:0]       op_q;
	logic [5:0]       cnt_q;
	logic [63:0]      mul_a_q;
	logic [127:0]     mul_p_q;
	logic [63:0]      t0_q, va_q, vb_q, num_q;
	logic [127:0]     d_q;
	logic signed [SW-1:0] r_q, p_q, qs_q, dsh_q, s_q;
	logic [4:0]       bit_q;
	logic [30:0]      q_q;
	logic [31:0]      corr_q;
	logic             deg_q, ovf_q;

	logic [63:0]      op_x, op_y, lo, mag, t0_lo;
	logic [64:0]      mul_sum;
	logic signed [SW-1:0] t_sum, qs_add;
	logic             fits, deg;
	logic [30:0]      q_nx;

	assign lo      = mul_p_q[63:0];
	assign mag     = abs64(num_q);
	assign mul_sum = {1'b0, mul_p_q[127:64]} + (mul_p_q[0] ? {1'b0, mul_a_q} : 65'd0);
	assign t_sum   = s_q + dsh_q;
	assign qs_add  = qs_q + (dsh_q <<< 1);
	assign fits    = t_sum <= r_q;
	assign q_nx    = fits ? (q_q | (31'd1 << bit_q)) : q_q;
	assign deg     = (va_q == 64'd0) || (vb_q == 64'd0);
	assign t0_lo   = snap_q.sab[47] ? 64'd0 - lo : lo;

	always_comb begin
		case (op_q)
			OP_N_SAA: begin op_x = 64'(snap_q.n); op_y = 64'(snap_q.saa); end
			OP_SA_SQ: begin op_x = abs64(64'(snap_q.sa)); op_y = abs64(64'(snap_q.sa)); end
			OP_N_SBB: begin op_x = 64'(snap_q.n); op_y = 64'(snap_q.sbb); end
			OP_SB_SQ: begin op_x = abs64(64'(snap_q.sb)); op_y = abs64(64'(snap_q.sb)); end
			OP_N_SAB: begin op_x = 64'(snap_q.n); op_y = abs64(64'(snap_q.sab)); end
			OP_SA_SB: begin op_x = abs64(64'(snap_q.sa)); op_y = abs64(64'(snap_q.sb)); end
			OP_VAR:   begin op_x = va_q; op_y = vb_q; end
			default:  begin op_x = mag; op_y = mag; end
		endcase
	end

	assign pop          = (st_q == ST_IDLE) && !empty;
	assign result.valid = st_q == ST_DONE;
	assign result.correlation = $signed(corr_q);
	assign result.degenerate  = deg_q;
	assign result.overflow    = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			op_q  <= OP_N_SAA;
			cnt_q <= '0;
			bit_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (!empty) begin
						op_q <= OP_N_SAA;
						st_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					st_q  <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd63) begin
						st_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (op_q == OP_SA_SB && deg) begin
						st_q <= ST_DONE;
					end else if (op_q == OP_MAG) begin
						bit_q <= 5'd30;
						st_q  <= ST_SRCH_A;
					end else begin
						op_q <= op_q + 1'b1;
						st_q <= ST_LOAD;
					end
				end
				ST_SRCH_A: st_q <= ST_SRCH_B;
				ST_SRCH_B: begin
					if (bit_q == 5'd0) begin
						st_q <= ST_DONE;
					end else begin
						bit_q <= bit_q - 1'b1;
						st_q  <= ST_SRCH_A;
					end
				end
				ST_DONE: begin
					if (result.ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				snap_q <= snap;
				ovf_q  <= snap.ovf;
			end
			ST_LOAD: begin
				mul_a_q <= op_x;
				mul_p_q <= {64'd0, op_y};
			end
			ST_MUL: mul_p_q <= {mul_sum, mul_p_q[63:1]};
			ST_POST: begin
				case (op_q)
					OP_N_SAA: t0_q <= lo;
					OP_SA_SQ: va_q <= t0_q - lo;
					OP_N_SBB: t0_q <= lo;
					OP_SB_SQ: vb_q <= t0_q - lo;
					OP_N_SAB: t0_q <= t0_lo;
					OP_SA_SB: begin
						num_q  <= t0_q - ((snap_q.sa[32] ^ snap_q.sb[32]) ? 64'd0 - lo : lo);
						corr_q <= '0;
						deg_q  <= deg;
					end
					OP_VAR: d_q <= mul_p_q;
					default: begin
						// start from q = 0, where k = 2q - 1 = -1
						r_q   <= $signed(SW'({mul_p_q, 62'd0}));
						p_q   <= $signed(SW'(d_q));
						qs_q  <= $signed(SW'(0) - (SW'(d_q) << 32));
						dsh_q <= $signed(SW'(d_q) << 62);
						q_q   <= '0;
					end
				endcase
			end
			ST_SRCH_A: s_q <= p_q + qs_q;
			ST_SRCH_B: begin
				if (fits) begin
					p_q  <= t_sum;
					qs_q <= qs_add >>> 1;
				end else begin
					qs_q <= qs_q >>> 1;
				end
				dsh_q <= dsh_q >>> 2;
				q_q   <= q_nx;
				corr_q <= num_q[63] ? 32'd0 - {1'b0, q_nx} : {1'b0, q_nx};
			end
			default: begin
			end
		endcase
	end

	`PCC_IMPLY(a_deg_zero, st_q == ST_DONE && deg_q, corr_q == 32'd0)
	`PCC_IMPLY(a_corr_rng, st_q == ST_DONE, $signed(corr_q) <= 32'sd1073741824 && $signed(corr_q) >= -32'sd1073741824)
	`PCC_IMPLY(a_done_src, st_q == ST_DONE && $past(st_q) != ST_DONE, $past(st_q) == ST_SRCH_B || $past(st_q) == ST_POST)

endmodule

/* sv/pearson_correlation.sv */
// ----------------------------------------------------------------------------
// Pearson correlation of two streamed vectors
// Element pairs in, one Q2.30 coefficient out per pair marked last.
// ----------------------------------------------------------------------------
// Usage:
//   pairs  : valid/ready channel, one item per element pair (sample_a,
//            sample_b, last). Pairs are taken at one per cycle while the
//            snapshot queue has room; only the last pair of a vector needs
//            a free queue slot, but ready drops whenever the queue is full.
//   result : valid/ready channel, one item per vector: correlation in Q2.30
//            (2^30 is +1), degenerate when either variance is zero (value
//            then 0) and overflow when more than MAX_LEN pairs arrived.
// Sequence: after the last pair the finishing unit runs eight passes of its
//   shift-add multiplier, each with a load and a post step, and then finds
//   31 quotient bits, each through the search steps A and B; a degenerate
//   vector finishes after six passes. One vector is finished at a time, so
//   the next snapshot is taken only once the result has been handed over,
//   while accumulation of the next vectors goes on.
// Reset: arst_n clears the sums, the queue and the finishing sequencer.
// Stall: a result holds on the port until taken; up to two further
//   vectors wait in the queue, after which pairs are held off.
// ----------------------------------------------------------------------------
module pearson_correlation (
	input  logic      clk,
	input  logic      arst_n,
	pcc_in_if.sink    pairs,
	pcc_out_if.source result
);

	// front end to queue
	logic           push, full;
	pcc_pkg::snap_t snap_in;

	// queue to finishing unit
	logic           pop, empty;
	pcc_pkg::snap_t snap_out;

	// accumulate pairs, push a snapshot on the last one
	pcc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs),
		.full   (full),
		.push   (push),
		.snap   (snap_in)
	);

	// decouple accumulation from the long finishing pass
	pcc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (snap_in),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (snap_out)
	);

	// variances, covariance and the rounded quotient
	pcc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.snap   (snap_out),
		.pop    (pop),
		.result (result)
	);

endmodule
